// File: src/obp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_pkg: shared types and helpers for the oriented box point query
// Request/result structs, register map, stage bundles and saturation.
// ----------------------------------------------------------------------------
package obp_pkg;

	// register map
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd5;

	// reset values
	localparam logic [31:0] RST_CENTER  = 32'd0;
	localparam logic [15:0] RST_AXIS_X  = 16'd16384;
	localparam logic [15:0] RST_AXIS_Y  = 16'd0;
	localparam logic [30:0] RST_HALF    = 31'd32768;

	// saturation limits
	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
	} query_t;

	typedef struct packed {
		logic               inside_res;
		logic signed [31:0] nearest_x;
		logic signed [31:0] nearest_y;
	} result_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic        [30:0] half_width;
		logic        [30:0] half_height;
	} cfg_t;

	// projection stage output
	typedef struct packed {
		logic               vld;
		query_t             query;
		logic signed [31:0] pi;
		logic signed [31:0] pj;
	} proj_t;

	// clamp stage output
	typedef struct packed {
		logic               vld;
		logic               in_box;
		query_t             query;
		logic signed [31:0] ci;
		logic signed [31:0] cj;
	} clamp_t;

	// saturate a 36 bit signed value to 32 bits
	function automatic logic [31:0] sat36(input logic [35:0] v);
		logic [31:0] r;
		if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
			r = v[31:0];
		end else if (v[35]) begin
			r = S32_MIN;
		end else begin
			r = S32_MAX;
		end
		return r;
	endfunction

endpackage

// File: src/obp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_cfg_regs: box configuration registers
// Holds center, i-axis and half extents; writes beyond the map are dropped.
// ----------------------------------------------------------------------------
module obp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [obp_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]                   cfg_wdata,
	output obp_pkg::cfg_t                 cfg
);

	obp_pkg::cfg_t cfg_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= obp_pkg::RST_CENTER;
			cfg_q.center_y    <= obp_pkg::RST_CENTER;
			cfg_q.axis_x      <= obp_pkg::RST_AXIS_X;
			cfg_q.axis_y      <= obp_pkg::RST_AXIS_Y;
			cfg_q.half_width  <= obp_pkg::RST_HALF;
			cfg_q.half_height <= obp_pkg::RST_HALF;
		end else if (cfg_wr) begin
			case (cfg_addr)
				obp_pkg::REG_CENTER_X:    cfg_q.center_x    <= cfg_wdata;
				obp_pkg::REG_CENTER_Y:    cfg_q.center_y    <= cfg_wdata;
				obp_pkg::REG_AXIS_X:      cfg_q.axis_x      <= cfg_wdata[15:0];
				obp_pkg::REG_AXIS_Y:      cfg_q.axis_y      <= cfg_wdata[15:0];
				obp_pkg::REG_HALF_WIDTH:  cfg_q.half_width  <= cfg_wdata[30:0];
				obp_pkg::REG_HALF_HEIGHT: cfg_q.half_height <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/obp_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_project: offset and axis projection, three stages
// s1 offset from center, s2 axis products, s3 sums floored to Q16.16 and
// saturated.
// ----------------------------------------------------------------------------
module obp_project (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  obp_pkg::query_t query,
	input  obp_pkg::cfg_t   cfg,
	output obp_pkg::proj_t  proj
);

	logic               vld_s1, vld_s2, vld_s3;
	obp_pkg::query_t    query_s1, query_s2, query_s3;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [48:0] dxax_s2, dyay_s2, dyax_s2, dxay_s2;
	logic signed [49:0] sum_i, sum_j;
	logic signed [31:0] pi_s3, pj_s3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// s1: exact offset from center
	always_ff @(posedge clk) begin
		query_s1 <= query;
		dx_s1    <= $signed({query.query_x[31], query.query_x})
			- $signed({cfg.center_x[31], cfg.center_x});
		dy_s1    <= $signed({query.query_y[31], query.query_y})
			- $signed({cfg.center_y[31], cfg.center_y});
	end

	// s2: offset times axis components
	always_ff @(posedge clk) begin
		query_s2 <= query_s1;
		dxax_s2  <= dx_s1 * $signed(cfg.axis_x);
		dyay_s2  <= dy_s1 * $signed(cfg.axis_y);
		dyax_s2  <= dy_s1 * $signed(cfg.axis_x);
		dxay_s2  <= dx_s1 * $signed(cfg.axis_y);
	end

	// s3: sum, floor by 2^14, saturate
	assign sum_i = $signed({dxax_s2[48], dxax_s2}) + $signed({dyay_s2[48], dyay_s2});
	assign sum_j = $signed({dyax_s2[48], dyax_s2}) - $signed({dxay_s2[48], dxay_s2});

	always_ff @(posedge clk) begin
		query_s3 <= query_s2;
		pi_s3    <= obp_pkg::sat36(sum_i[49:14]);
		pj_s3    <= obp_pkg::sat36(sum_j[49:14]);
	end

	assign proj.vld   = vld_s3;
	assign proj.query = query_s3;
	assign proj.pi    = pi_s3;
	assign proj.pj    = pj_s3;

endmodule

// File: src/obp_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_clamp: inside test and projection clamp, one stage
// Compares absolute projections with the half extents and clamps them.
// ----------------------------------------------------------------------------
module obp_clamp (
	input  logic             clk,
	input  logic             arst_n,
	input  obp_pkg::proj_t   proj,
	input  obp_pkg::cfg_t    cfg,
	output obp_pkg::clamp_t  clmp
);

	logic [32:0]        api, apj;
	logic signed [31:0] hw, hh;
	logic signed [31:0] ci, cj;
	logic               in_box;
	logic               vld_s4;
	logic               inside_s4;
	obp_pkg::query_t    query_s4;
	logic signed [31:0] ci_s4, cj_s4;

	// magnitudes, a projection of the most negative value has magnitude 2^31
	assign api = proj.pi[31] ? -{1'b1, proj.pi} : {1'b0, proj.pi};
	assign apj = proj.pj[31] ? -{1'b1, proj.pj} : {1'b0, proj.pj};

	assign hw = $signed({1'b0, cfg.half_width});
	assign hh = $signed({1'b0, cfg.half_height});

	assign in_box = (api < {2'b00, cfg.half_width}) && (apj < {2'b00, cfg.half_height});

	// clamp each projection to [-half, +half]
	always_comb begin
		if (proj.pi > hw) begin
			ci = hw;
		end else if (proj.pi < -hw) begin
			ci = -hw;
		end else begin
			ci = proj.pi;
		end
		if (proj.pj > hh) begin
			cj = hh;
		end else if (proj.pj < -hh) begin
			cj = -hh;
		end else begin
			cj = proj.pj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= proj.vld;
		end
	end

	always_ff @(posedge clk) begin
		inside_s4 <= in_box;
		query_s4  <= proj.query;
		ci_s4     <= ci;
		cj_s4     <= cj;
	end

	assign clmp.vld    = vld_s4;
	assign clmp.in_box = inside_s4;
	assign clmp.query  = query_s4;
	assign clmp.ci     = ci_s4;
	assign clmp.cj     = cj_s4;

	// clamped values stay within the half extents
	a_ci_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (ci_s4 <= hw) && (ci_s4 >= -hw))
		else $error("clamped i projection outside half width");

	a_cj_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (cj_s4 <= hh) && (cj_s4 >= -hh))
		else $error("clamped j projection outside half height");

	// an inside point is never clamped
	a_inside_unclamped: assert property (@(posedge clk) disable iff (!arst_n)
		proj.vld |=> !inside_s4 || ((ci_s4 == $past(proj.pi)) && (cj_s4 == $past(proj.pj))))
		else $error("inside point had its projection clamped");

endmodule

// File: src/obp_rebuild.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obp_rebuild: nearest point from clamped projections, two stages
// s5 products with the axis, s6 floor, add center, saturate and select.
// ----------------------------------------------------------------------------
module obp_rebuild (
	input  logic             clk,
	input  logic             arst_n,
	input  obp_pkg::clamp_t  clmp,
	input  obp_pkg::cfg_t    cfg,
	output logic             done,
	output obp_pkg::result_t result
);

	logic               vld_s5, vld_s6;
	logic               inside_s5;
	obp_pkg::query_t    query_s5;
	logic signed [47:0] ciax_s5, cjay_s5, ciay_s5, cjax_s5;
	logic signed [48:0] sum_x, sum_y;
	logic signed [35:0] nx_wide, ny_wide;
	obp_pkg::result_t   result_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= clmp.vld;
			vld_s6 <= vld_s5;
		end
	end

	// s5: clamped projections times axis components
	always_ff @(posedge clk) begin
		inside_s5 <= clmp.in_box;
		query_s5  <= clmp.query;
		ciax_s5   <= clmp.ci * $signed(cfg.axis_x);
		cjay_s5   <= clmp.cj * $signed(cfg.axis_y);
		ciay_s5   <= clmp.ci * $signed(cfg.axis_y);
		cjax_s5   <= clmp.cj * $signed(cfg.axis_x);
	end

	// s6: sum, floor by 2^14, offset by center
	assign sum_x = $signed({ciax_s5[47], ciax_s5}) - $signed({cjay_s5[47], cjay_s5});
	assign sum_y = $signed({ciay_s5[47], ciay_s5}) + $signed({cjax_s5[47], cjax_s5});

	assign nx_wide = $signed({sum_x[48], sum_x[48:14]})
		+ $signed({{4{cfg.center_x[31]}}, cfg.center_x});
	assign ny_wide = $signed({sum_y[48], sum_y[48:14]})
		+ $signed({{4{cfg.center_y[31]}}, cfg.center_y});

	// output register, inside points pass through unchanged
	always_ff @(posedge clk) begin
		result_s6.inside_res <= inside_s5;
		if (inside_s5) begin
			result_s6.nearest_x <= query_s5.query_x;
			result_s6.nearest_y <= query_s5.query_y;
		end else begin
			result_s6.nearest_x <= obp_pkg::sat36(nx_wide);
			result_s6.nearest_y <= obp_pkg::sat36(ny_wide);
		end
	end

	assign done   = vld_s6;
	assign result = result_s6;

endmodule

// File: src/obb_point_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_point_query: nearest point on a fixed 2D oriented box
//
// Configuration: write cfg_wdata to register cfg_addr when cfg_wr is high
// (center x/y, axis x/y, half width/height); only while no request is in
// flight. Reset loads a unit box of half extent 0.5 at the origin, axis x=1.
// Requests: a query point on query is taken at every clock edge with start
// high; busy is always low, so one request per cycle is sustained.
// Results: done pulses for one cycle with result holding the inside flag
// and nearest point. A request passes through the six register stages in
// order: offset, projection products, projection sum, clamp, rebuild
// products, rebuild sum. Results come out in request order.
// The receiver cannot stall; results are not held. Reset empties the
// pipeline and drops any request in flight.
// ----------------------------------------------------------------------------
module obb_point_query (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  obp_pkg::query_t               query,
	output logic                          done,
	output obp_pkg::result_t              result,
	input  logic                          cfg_wr,
	input  logic [obp_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]                   cfg_wdata
);

	obp_pkg::cfg_t   cfg;
	obp_pkg::proj_t  proj;
	obp_pkg::clamp_t clmp;
	logic            accept;

	// fully pipelined, never back-pressures
	assign busy   = 1'b0;
	assign accept = start && !busy;

	obp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	obp_project u_project (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.query  (query),
		.cfg    (cfg),
		.proj   (proj)
	);

	obp_clamp u_clamp (
		.clk    (clk),
		.arst_n (arst_n),
		.proj   (proj),
		.cfg    (cfg),
		.clmp   (clmp)
	);

	obp_rebuild u_rebuild (
		.clk    (clk),
		.arst_n (arst_n),
		.clmp   (clmp),
		.cfg    (cfg),
		.done   (done),
		.result (result)
	);

	// every request produces exactly one result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("request without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result without request");

	// inside points return the query unchanged
	a_inside_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.inside_res |->
			(result.nearest_x == $past(query.query_x, 6)) &&
			(result.nearest_y == $past(query.query_y, 6)))
		else $error("inside result differs from query point");

endmodule
